// ----- rtl/pdl_pkg.sv -----
// Shared types and widths for the point-to-line distance block.
// Used by every module under rtl; depends on nothing.
package pdl_pkg;

    localparam int COORD_W = 32;                  // signed Q16.16 coordinate
    localparam int DIFF_W  = COORD_W + 1;         // p - M
    localparam int PROD_W  = DIFF_W + COORD_W;    // one cross-product term
    localparam int MAG_W   = PROD_W;              // magnitude of a cross component
    localparam int LO_W    = (MAG_W + 1) / 2;     // low split of a magnitude
    localparam int HI_W    = MAG_W - LO_W;        // high split of a magnitude
    localparam int SQ_W    = 2 * MAG_W;           // one squared component
    localparam int ACC_W   = SQ_W + 2;            // |c|^2 and root working width
    localparam int USQ_W   = 2 * COORD_W + 2;     // |u|^2
    localparam int DIST_W  = 32;                  // distance word
    localparam int IDX_W   = 3;                   // register index width

    // Register indexes of the configuration port
    typedef enum logic [IDX_W-1:0] {
        REG_BASE_X = 3'd0,
        REG_BASE_Y = 3'd1,
        REG_BASE_Z = 3'd2,
        REG_DIR_X  = 3'd3,
        REG_DIR_Y  = 3'd4,
        REG_DIR_Z  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
        logic signed [COORD_W-1:0] query_z;
    } t_query;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              on_line;
        logic              zero_direction;
        logic              saturated;
    } t_result;

    // Data handed from one root cell to the next
    typedef struct packed {
        logic              valid;
        logic [ACC_W-1:0]  csq;    // |c|^2
        logic [ACC_W-1:0]  usq;    // |u|^2
        logic [ACC_W-1:0]  acc;    // q*q*U
        logic [ACC_W-1:0]  lin;    // q*U
        logic [DIST_W-1:0] root;   // q so far
        logic              zdir;
        logic              sat;
        logic              czero;
    } t_cell_bus;

endpackage

// ----- rtl/point_to_line_distance.sv -----
// Top level of the point-to-line distance block: line registers, front pipeline,
// chain of root cells and the result register. Depends on pdl_pkg, pdl_front,
// pdl_root_cell.
//
//   channel   handshake            payload
//   request   start / busy         i_query  (t_query)
//   result    o_valid strobe       o_result (t_result)
//   config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// One request per cycle; busy is always low. Each result passes through
// 6 front stages, one root cell per distance bit (32) and one output register.
// The root chain sets the latency. Synchronous reset clears the valid
// flags and loads the line as base 0, direction 1.0 along x. The receiver cannot
// stall; every result is shown for one cycle.
module point_to_line_distance (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pdl_pkg::t_query               i_query,
    output logic                          o_valid,
    output pdl_pkg::t_result              o_result,
    input  logic                          i_cfg_we,
    input  logic [pdl_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [pdl_pkg::COORD_W-1:0]   i_cfg_data
);
    localparam int CW = pdl_pkg::COORD_W;
    localparam int NC = pdl_pkg::DIST_W;

    logic signed [CW-1:0] r_base [3];
    logic signed [CW-1:0] r_dir  [3];
    pdl_pkg::t_cell_bus   w_bus [NC+1];
    pdl_pkg::t_result     r_result;
    logic                 r_valid;

    // Write the line registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base[0] <= '0;
            r_base[1] <= '0;
            r_base[2] <= '0;
            r_dir[0]  <= CW'(65536);
            r_dir[1]  <= '0;
            r_dir[2]  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pdl_pkg::REG_BASE_X: r_base[0] <= i_cfg_data;
                pdl_pkg::REG_BASE_Y: r_base[1] <= i_cfg_data;
                pdl_pkg::REG_BASE_Z: r_base[2] <= i_cfg_data;
                pdl_pkg::REG_DIR_X:  r_dir[0]  <= i_cfg_data;
                pdl_pkg::REG_DIR_Y:  r_dir[1]  <= i_cfg_data;
                pdl_pkg::REG_DIR_Z:  r_dir[2]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    pdl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_query (i_query),
        .i_base  (r_base),
        .i_dir   (r_dir),
        .o_bus   (w_bus[0])
    );

    // One cell per distance bit, most significant first
    for (genvar k = 0; k < NC; k++) begin : g_cell
        pdl_root_cell #(
            .BIT (NC - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (w_bus[k]),
            .o_bus   (w_bus[k+1])
        );
    end

    // Form the result flags and hold them for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_bus[NC].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.zero_direction <= w_bus[NC].zdir;
        r_result.saturated      <= ~w_bus[NC].zdir & w_bus[NC].sat;
        r_result.on_line        <= ~w_bus[NC].zdir & ~w_bus[NC].sat & w_bus[NC].czero;
        if (w_bus[NC].zdir) begin
            r_result.distance <= '0;
        end else if (w_bus[NC].sat) begin
            r_result.distance <= '1;
        end else begin
            r_result.distance <= w_bus[NC].root;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

// ----- rtl/pdl_front.sv -----
// Front pipeline: offset, cross product, squared norms and range check.
// Depends on pdl_pkg; feeds the first root cell.
module pdl_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  pdl_pkg::t_query                    i_query,
    input  logic signed [pdl_pkg::COORD_W-1:0] i_base [3],
    input  logic signed [pdl_pkg::COORD_W-1:0] i_dir  [3],
    output pdl_pkg::t_cell_bus                 o_bus
);
    localparam int CW = pdl_pkg::COORD_W;
    localparam int DW = pdl_pkg::DIFF_W;
    localparam int PW = pdl_pkg::PROD_W;
    localparam int MW = pdl_pkg::MAG_W;
    localparam int LW = pdl_pkg::LO_W;
    localparam int HW = pdl_pkg::HI_W;
    localparam int SW = pdl_pkg::SQ_W;
    localparam int AW = pdl_pkg::ACC_W;
    localparam int UW = pdl_pkg::USQ_W;

    logic [4:0] r_vld;
    logic [4:0] r_zd;

    logic signed [DW-1:0] r_d    [3];
    logic        [CW-1:0] r_um   [3];
    logic signed [PW-1:0] r_p    [6];
    logic    [2*CW-1:0]   r_usq  [3];
    logic        [MW-1:0] r_m    [3];
    logic        [UW-1:0] r_u3, r_u4, r_u5;
    logic    [2*HW-1:0]   r_hh   [3];
    logic   [HW+LW-1:0]   r_hl   [3];
    logic    [2*LW-1:0]   r_ll   [3];
    logic        [SW-1:0] r_sq   [3];
    pdl_pkg::t_cell_bus   r_bus;

    logic signed [DW-1:0] n_q [3];
    logic signed [PW:0]   n_c [3];
    logic        [PW:0]   n_cm [3];
    logic        [AW-1:0] n_csq;

    assign n_q[0] = DW'(i_query.query_x);
    assign n_q[1] = DW'(i_query.query_y);
    assign n_q[2] = DW'(i_query.query_z);

    // Cross product components, sign extended one bit, then magnitudes
    always_comb begin
        n_c[0] = {r_p[0][PW-1], r_p[0]} - {r_p[1][PW-1], r_p[1]};
        n_c[1] = {r_p[2][PW-1], r_p[2]} - {r_p[3][PW-1], r_p[3]};
        n_c[2] = {r_p[4][PW-1], r_p[4]} - {r_p[5][PW-1], r_p[5]};
        for (int i = 0; i < 3; i++) begin
            n_cm[i] = n_c[i][PW] ? (~n_c[i] + 1'b1) : n_c[i];
        end
        n_csq = AW'(r_sq[0]) + AW'(r_sq[1]) + AW'(r_sq[2]);
    end

    // Advance the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        r_zd <= {r_zd[3:0], (i_dir[0] == '0) && (i_dir[1] == '0) && (i_dir[2] == '0)};

        // offset from the base point and |u| components
        for (int i = 0; i < 3; i++) begin
            r_d[i]  <= n_q[i] - DW'(i_base[i]);
            r_um[i] <= i_dir[i][CW-1] ? (~i_dir[i] + 1'b1) : i_dir[i];
        end

        // cross-product terms and squares of u
        r_p[0] <= r_d[1] * i_dir[2];
        r_p[1] <= r_d[2] * i_dir[1];
        r_p[2] <= r_d[2] * i_dir[0];
        r_p[3] <= r_d[0] * i_dir[2];
        r_p[4] <= r_d[0] * i_dir[1];
        r_p[5] <= r_d[1] * i_dir[0];
        for (int i = 0; i < 3; i++) begin
            r_usq[i] <= r_um[i] * r_um[i];
        end

        // magnitudes and |u|^2
        for (int i = 0; i < 3; i++) begin
            r_m[i] <= n_cm[i][MW-1:0];
        end
        r_u3 <= UW'(r_usq[0]) + UW'(r_usq[1]) + UW'(r_usq[2]);

        // split squares into partial products
        for (int i = 0; i < 3; i++) begin
            r_hh[i] <= r_m[i][MW-1:LW] * r_m[i][MW-1:LW];
            r_hl[i] <= r_m[i][MW-1:LW] * r_m[i][LW-1:0];
            r_ll[i] <= r_m[i][LW-1:0] * r_m[i][LW-1:0];
        end
        r_u4 <= r_u3;

        // recombine each square
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= (SW'(r_hh[i]) << (2 * LW)) + (SW'(r_hl[i]) << (LW + 1))
                     + SW'(r_ll[i]);
        end
        r_u5 <= r_u4;

        // sum |c|^2 and check the range limit U * 2^(2*DIST_W)
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= r_vld[4];
        end
        r_bus.csq   <= n_csq;
        r_bus.usq   <= AW'(r_u5);
        r_bus.acc   <= '0;
        r_bus.lin   <= '0;
        r_bus.root  <= '0;
        r_bus.zdir  <= r_zd[4];
        r_bus.sat   <= (AW'(r_u5) << (2 * pdl_pkg::DIST_W)) <= n_csq;
        r_bus.czero <= (n_csq == '0);
    end

    assign o_bus = r_bus;
endmodule

// ----- rtl/pdl_root_cell.sv -----
// One root cell: tries one bit of the distance and passes the item on.
// Depends on pdl_pkg; chained in the top level.
module pdl_root_cell #(
    parameter int BIT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pdl_pkg::t_cell_bus i_bus,
    output pdl_pkg::t_cell_bus o_bus
);
    localparam int AW = pdl_pkg::ACC_W;
    localparam int DW = pdl_pkg::DIST_W;

    logic [AW-1:0] n_try;
    logic          n_take;
    pdl_pkg::t_cell_bus r_bus;

    // (q + 2^b)^2 U = qqU + 2^(b+1) qU + 2^(2b) U
    always_comb begin
        n_try  = i_bus.acc + (i_bus.lin << (BIT + 1)) + (i_bus.usq << (2 * BIT));
        n_take = (n_try <= i_bus.csq);
    end

    // Keep the bit when the trial still fits under |c|^2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= i_bus.valid;
        end
        r_bus.csq   <= i_bus.csq;
        r_bus.usq   <= i_bus.usq;
        r_bus.zdir  <= i_bus.zdir;
        r_bus.sat   <= i_bus.sat;
        r_bus.czero <= i_bus.czero;
        if (n_take) begin
            r_bus.acc  <= n_try;
            r_bus.lin  <= i_bus.lin + (i_bus.usq << BIT);
            r_bus.root <= i_bus.root | (DW'(1) << BIT);
        end else begin
            r_bus.acc  <= i_bus.acc;
            r_bus.lin  <= i_bus.lin;
            r_bus.root <= i_bus.root;
        end
    end

    assign o_bus = r_bus;
endmodule
